FILE: rtl/utf8_stream_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared property forms for the decoder's checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_STREAM_DECODER_TOP_ASSERT_SVH

// Same-cycle implication
`define USD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define USD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/usd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Types, constants and register map shared by the decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package usd_pkg;

  // Default saturation limit of the per-buffer character count
  localparam longint unsigned COUNT_MAX_DEF = 64'd65536;

  // Field widths
  localparam int CP_W      = 31;
  localparam int COUNT_W   = 17;
  localparam int DATA_W    = 8;

  // Queue depths
  localparam int QUEUE_DEPTH = 2;

  // Held sequence bytes
  localparam int HOLD_DEPTH = 5;
  localparam int HOLD_IDX_W = $clog2(HOLD_DEPTH);
  localparam int HOLD_CNT_W = $clog2(HOLD_DEPTH + 1);
  localparam int NEED_W     = 3;
  localparam int LEAD_W     = 5;

  // Lead payload masks
  localparam logic [7:0] MASK_LEAD2 = 8'h1F;
  localparam logic [7:0] MASK_LEAD3 = 8'h0F;
  localparam logic [7:0] MASK_LEAD4 = 8'h07;
  localparam logic [7:0] MASK_LEAD5 = 8'h03;
  localparam logic [7:0] MASK_LEAD6 = 8'h01;
  localparam logic [7:0] MASK_CONT  = 8'h3F;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_FORCE_MODE = 1'b0;

  // Byte class, decided at the front
  typedef enum logic [1:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD,
    CLS_BAD
  } byte_cls_t;

  // Classified input item
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              eob;
    byte_cls_t         cls;
    logic [NEED_W-1:0] need;
    logic [LEAD_W-1:0] lead_bits;
  } item_t;

  // Result item
  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic               decode_failed;
    logic               run_last;
    logic               buffer_done;
    logic [COUNT_W-1:0] char_count;
  } result_t;

  // Back-end sequencer state
  typedef enum logic {
    ST_PROC,
    ST_FLUSH
  } seq_state_t;

endpackage

FILE: rtl/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder, top level
// Decodes a byte stream in legacy 1-to-6-byte UTF-8 into code points.
// ----------------------------------------------------------------------------
// Bytes enter through a push/full queue and results leave through an
// empty/pop queue. A well-formed stream runs at one byte per clock while
// results are popped; a byte is registered in the input queue and its result
// in the result queue before that result is on the output ports. The back-end
// sequencer writes one result per cycle while the result queue has room, so a
// byte that breaks a sequence in force mode has the held bytes flushed raw
// first and is then handled itself; a lead that ends the buffer is then also
// flushed raw. An aborted buffer's trailing bytes are dropped at one per cycle
// while the result queue has room. force_mode sits at byte address 0 of the
// APB port and may only be changed while the decoder is idle. Character
// counts saturate at COUNT_MAX. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module utf8_stream_decoder_top #(
  parameter longint unsigned COUNT_MAX = usd_pkg::COUNT_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input queue
  input  logic                           push,
  output logic                           full,
  input  logic [usd_pkg::DATA_W-1:0]     in_data_byte,
  input  logic                           in_end_of_buffer,
  // Result queue
  output logic                           empty,
  input  logic                           pop,
  output logic [usd_pkg::CP_W-1:0]       out_code_point,
  output logic                           out_decode_failed,
  output logic                           out_run_last,
  output logic                           out_buffer_done,
  output logic [usd_pkg::COUNT_W-1:0]    out_char_count,
  // Configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [usd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [usd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [usd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  import usd_pkg::*;

  logic                    force_mode_r, force_mode_nxt;
  logic [REG_IDX_W-1:0]    reg_idx;
  logic                    reg_hit;
  logic                    head_valid;
  item_t                   head;
  logic                    head_pop;
  logic                    res_full;
  logic                    res_push;
  result_t                 res;
  logic [$bits(result_t)-1:0] out_bits;
  result_t                 out_item;

  // Decode the register address
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_FORCE_MODE);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? CFG_DATA_W'(force_mode_r) : '0;

  // Write the mode register on the access phase
  always_comb begin
    force_mode_nxt = force_mode_r;
    if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_FORCE_MODE: force_mode_nxt = pwdata[0];
        default:        force_mode_nxt = force_mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_mode_r <= 1'b0;
    end else begin
      force_mode_r <= force_mode_nxt;
    end
  end

  usd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .data_byte     (in_data_byte),
    .end_of_buffer (in_end_of_buffer),
    .head_valid    (head_valid),
    .head          (head),
    .head_pop      (head_pop)
  );

  usd_back #(
    .COUNT_MAX (COUNT_MAX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .force_mode (force_mode_r),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  // Queue results toward the consumer
  usd_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_bits),
    .empty   (empty)
  );

  assign out_item          = result_t'(out_bits);
  assign out_code_point    = out_item.code_point;
  assign out_decode_failed = out_item.decode_failed;
  assign out_run_last      = out_item.run_last;
  assign out_buffer_done   = out_item.buffer_done;
  assign out_char_count    = out_item.char_count;

endmodule

FILE: rtl/usd_fifo.sv
// ----------------------------------------------------------------------------
// Small register FIFO
// Generic first-in first-out queue with full/empty flags, used between stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/usd_front.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts bytes, classifies each as ASCII, continuation, lead or bad, and
// queues the classified item for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic [usd_pkg::DATA_W-1:0] data_byte,
  input  logic                      end_of_buffer,
  output logic                      head_valid,
  output usd_pkg::item_t            head,
  input  logic                      head_pop
);

  import usd_pkg::*;

  item_t                  item;
  logic [$bits(item_t)-1:0] head_bits;
  logic                   q_empty;

  // Classify the incoming byte and extract lead payload bits
  always_comb begin
    item.data      = data_byte;
    item.eob       = end_of_buffer;
    item.cls       = CLS_BAD;
    item.need      = '0;
    item.lead_bits = '0;
    if (data_byte inside {[8'h00:8'h7F]}) begin
      item.cls = CLS_ASCII;
    end else if (data_byte inside {[8'h80:8'hBF]}) begin
      item.cls = CLS_CONT;
    end else if (data_byte inside {[8'hC0:8'hDF]}) begin
      item.cls       = CLS_LEAD;
      item.need      = NEED_W'(1);
      item.lead_bits = LEAD_W'(data_byte & MASK_LEAD2);
    end else if (data_byte inside {[8'hE0:8'hEF]}) begin
      item.cls       = CLS_LEAD;
      item.need      = NEED_W'(2);
      item.lead_bits = LEAD_W'(data_byte & MASK_LEAD3);
    end else if (data_byte inside {[8'hF0:8'hF7]}) begin
      item.cls       = CLS_LEAD;
      item.need      = NEED_W'(3);
      item.lead_bits = LEAD_W'(data_byte & MASK_LEAD4);
    end else if (data_byte inside {[8'hF8:8'hFB]}) begin
      item.cls       = CLS_LEAD;
      item.need      = NEED_W'(4);
      item.lead_bits = LEAD_W'(data_byte & MASK_LEAD5);
    end else if (data_byte inside {[8'hFC:8'hFD]}) begin
      item.cls       = CLS_LEAD;
      item.need      = NEED_W'(5);
      item.lead_bits = LEAD_W'(data_byte & MASK_LEAD6);
    end
  end

  // Queue classified items toward the back end
  usd_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (item),
    .full    (full),
    .rd_en   (head_pop),
    .rd_data (head_bits),
    .empty   (q_empty)
  );

  assign head       = item_t'(head_bits);
  assign head_valid = !q_empty;

endmodule

FILE: rtl/usd_back.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Sequencer that assembles code points from queued items, flushes held bytes
// raw on failure in force mode, aborts and discards buffers otherwise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_stream_decoder_top_assert.svh"

module usd_back #(
  parameter longint unsigned COUNT_MAX = usd_pkg::COUNT_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             force_mode,
  input  logic             head_valid,
  input  usd_pkg::item_t   head,
  output logic             head_pop,
  input  logic             res_full,
  output logic             res_push,
  output usd_pkg::result_t res
);

  import usd_pkg::*;

  localparam int CNT_W = $clog2(COUNT_MAX + 64'd1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(COUNT_MAX);

  seq_state_t            state_r, state_nxt;
  logic [CP_W-1:0]       acc_r, acc_nxt;
  logic [NEED_W-1:0]     need_r, need_nxt;
  logic [HOLD_CNT_W-1:0] held_cnt_r, held_cnt_nxt;
  logic [HOLD_IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic                  disc_r, disc_nxt;
  logic                  flush_end_r, flush_end_nxt;
  logic [DATA_W-1:0]     held_r [HOLD_DEPTH];

  logic                  hold_we;
  logic [HOLD_IDX_W-1:0] hold_waddr;
  logic [CNT_W-1:0]      cnt_inc;
  logic [CP_W-1:0]       acc_cont;
  logic                  last_idx;
  logic                  emit_en;
  logic [CP_W-1:0]       emit_cp;
  logic                  emit_last;
  logic                  emit_done;
  logic                  abort_en;

  assign cnt_inc  = (total_r < CNT_LIMIT) ? total_r + 1'b1 : total_r;
  assign acc_cont = {acc_r[CP_W-7:0], head.data[5:0]};
  assign last_idx = (HOLD_CNT_W'(idx_r) == held_cnt_r - 1'b1);

  // Next state, result and queue controls
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    need_nxt      = need_r;
    held_cnt_nxt  = held_cnt_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    disc_nxt      = disc_r;
    flush_end_nxt = flush_end_r;
    head_pop      = 1'b0;
    hold_we       = 1'b0;
    hold_waddr    = held_cnt_r[HOLD_IDX_W-1:0];
    emit_en       = 1'b0;
    emit_cp       = '0;
    emit_last     = 1'b0;
    emit_done     = 1'b0;
    abort_en      = 1'b0;
    res_push      = 1'b0;
    res           = '0;

    case (state_r)
      ST_PROC: begin
        if (head_valid && !res_full) begin
          if (disc_r) begin
            // Drop the rest of an aborted buffer
            head_pop = 1'b1;
            if (head.eob) begin
              disc_nxt  = 1'b0;
              total_nxt = '0;
            end
          end else if (held_cnt_r != '0) begin
            if (head.cls == CLS_CONT) begin
              // Extend the open sequence
              hold_we      = (held_cnt_r < HOLD_CNT_W'(HOLD_DEPTH));
              acc_nxt      = acc_cont;
              need_nxt     = need_r - 1'b1;
              held_cnt_nxt = held_cnt_r + 1'b1;
              if (need_r == NEED_W'(1)) begin
                emit_en      = 1'b1;
                emit_cp      = acc_cont;
                emit_last    = 1'b1;
                emit_done    = head.eob;
                head_pop     = 1'b1;
                held_cnt_nxt = '0;
                need_nxt     = '0;
                acc_nxt      = '0;
              end else if (!head.eob) begin
                head_pop = 1'b1;
              end else if (force_mode) begin
                head_pop      = 1'b1;
                state_nxt     = ST_FLUSH;
                flush_end_nxt = 1'b1;
                idx_nxt       = '0;
              end else begin
                abort_en = 1'b1;
              end
            end else if (force_mode) begin
              // Flush held bytes, then revisit this item by its class
              state_nxt     = ST_FLUSH;
              flush_end_nxt = 1'b0;
              idx_nxt       = '0;
            end else begin
              abort_en = 1'b1;
            end
          end else begin
            case (head.cls)
              CLS_ASCII: begin
                emit_en   = 1'b1;
                emit_cp   = CP_W'(head.data);
                emit_last = 1'b1;
                emit_done = head.eob;
                head_pop  = 1'b1;
              end
              CLS_LEAD: begin
                // Open a new sequence
                hold_we      = 1'b1;
                hold_waddr   = '0;
                held_cnt_nxt = HOLD_CNT_W'(1);
                need_nxt     = head.need;
                acc_nxt      = CP_W'(head.lead_bits);
                if (!head.eob) begin
                  head_pop = 1'b1;
                end else if (force_mode) begin
                  head_pop      = 1'b1;
                  state_nxt     = ST_FLUSH;
                  flush_end_nxt = 1'b1;
                  idx_nxt       = '0;
                end else begin
                  abort_en = 1'b1;
                end
              end
              default: begin
                // Bad byte or stray continuation: pass through or abort
                if (force_mode) begin
                  emit_en   = 1'b1;
                  emit_cp   = CP_W'(head.data);
                  emit_last = 1'b1;
                  emit_done = head.eob;
                  head_pop  = 1'b1;
                end else begin
                  abort_en = 1'b1;
                end
              end
            endcase
          end
        end
      end
      ST_FLUSH: begin
        // Emit one held byte raw per cycle while the result queue has room
        if (!res_full) begin
          emit_en   = 1'b1;
          emit_cp   = CP_W'(held_r[idx_r]);
          emit_last = last_idx &&
                      (flush_end_r || (head.cls == CLS_LEAD && !head.eob));
          emit_done = last_idx && flush_end_r;
          if (last_idx) begin
            state_nxt    = ST_PROC;
            held_cnt_nxt = '0;
            need_nxt     = '0;
            acc_nxt      = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_PROC;
      end
    endcase

    // Count and deliver a character
    if (emit_en) begin
      res_push            = 1'b1;
      res.code_point      = emit_cp;
      res.run_last        = emit_last;
      res.buffer_done     = emit_done;
      res.char_count      = COUNT_W'(cnt_inc);
      total_nxt           = emit_done ? '0 : cnt_inc;
    end

    // Abort the buffer with a single error result
    if (abort_en) begin
      res_push          = 1'b1;
      res.decode_failed = 1'b1;
      res.run_last      = 1'b1;
      res.buffer_done   = 1'b1;
      head_pop          = 1'b1;
      hold_we           = 1'b0;
      held_cnt_nxt      = '0;
      need_nxt          = '0;
      acc_nxt           = '0;
      total_nxt         = '0;
      disc_nxt          = !head.eob;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_PROC;
      acc_r       <= '0;
      need_r      <= '0;
      held_cnt_r  <= '0;
      idx_r       <= '0;
      total_r     <= '0;
      disc_r      <= 1'b0;
      flush_end_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      need_r      <= need_nxt;
      held_cnt_r  <= held_cnt_nxt;
      idx_r       <= idx_nxt;
      total_r     <= total_nxt;
      disc_r      <= disc_nxt;
      flush_end_r <= flush_end_nxt;
    end
  end

  // Hold sequence bytes for a raw flush
  always_ff @(posedge clk) begin
    if (hold_we) begin
      held_r[hold_waddr] <= head.data;
    end
  end

  `USD_ASSERT_NOW(a_flush_has_bytes, state_r == ST_FLUSH, held_cnt_r != '0, "flush without held bytes")
  `USD_ASSERT_NOW(a_disc_idle, disc_r, held_cnt_r == '0 && total_r == '0, "discard with open sequence")
  `USD_ASSERT_NEXT(a_done_clears, res_push && res.buffer_done, total_r == '0 && held_cnt_r == '0, "buffer end left state")
  `USD_ASSERT_NEXT(a_flush_step, state_r == ST_FLUSH && !res_full && !last_idx, state_r == ST_FLUSH && idx_r == $past(idx_r) + 1'b1, "flush index did not advance")

endmodule
